[rtl/rcnf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcnf_pkg
// Types and constants shared by the colour-name feature block.
// ----------------------------------------------------------------------------
package rcnf_pkg;

  localparam int unsigned BinW    = 15;
  localparam int unsigned ColorBins = 32768;
  localparam int unsigned RegW    = 13;
  localparam int unsigned AccW    = 40;
  localparam int unsigned ScaleW  = 30;
  localparam int unsigned ValW    = 17;
  localparam int unsigned QuotSteps = 17;

  localparam logic [1:0] ReqTblWrite = 2'd0;
  localparam logic [1:0] ReqPixel    = 2'd1;
  localparam logic [1:0] ReqFrameEnd = 2'd2;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatRegion = 2'd1;
  localparam logic [1:0] StatZero   = 2'd2;

  localparam logic [2:0] RegRoiLeft   = 3'd0;
  localparam logic [2:0] RegRoiTop    = 3'd1;
  localparam logic [2:0] RegRoiRight  = 3'd2;
  localparam logic [2:0] RegRoiBottom = 3'd3;
  localparam logic [2:0] RegImgWidth  = 3'd4;
  localparam logic [2:0] RegImgHeight = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SHIFT,
    S_MUL,
    S_ADD,
    S_SQRT,
    S_DINIT,
    S_DIV,
    S_LOAD
  } state_e;

endpackage
`default_nettype wire

[rtl/roi_color_name_feature_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Table writes and pixels are accepted back to back while the block is idle; the
// registered weight table read feeds the accumulators in the cycle after the pixel is taken.
// Frame end: a scaling shift search, a square per class, a bit-serial square root and
// a restoring divide per class, then one result per class, held by output stalls.
// Input is blocked while a frame end is processed. Reset clears the accumulators and
// control registers at once; the weight table has no reset and is never cleared.
// ----------------------------------------------------------------------------
// roi_color_name_feature_top
// Colour-name histogram over a region of interest with L2-normalized output.
// ----------------------------------------------------------------------------
module roi_color_name_feature_top #(
  parameter int unsigned FEATURE_CLASSES = 8,
  parameter int unsigned MAX_DIM         = 4096,
  parameter int unsigned WEIGHT_BITS     = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // bin_index[14:0] class_slot[17:15] weight_value[33:18] pixel_row[45:34]
  // pixel_col[57:46] red[65:58] green[73:66] blue[81:74]
  input  wire logic [87:0] s_axis_tdata_i,
  // req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // feature_class[2:0] feature_value[19:3] status[21:20]
  output logic      [23:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned LaneW = FEATURE_CLASSES * WEIGHT_BITS;
  localparam int unsigned ClsW  = (FEATURE_CLASSES > 1) ? $clog2(FEATURE_CLASSES) : 1;
  localparam int unsigned RegW  = rcnf_pkg::RegW;
  localparam int unsigned AccW  = rcnf_pkg::AccW;

  // Configuration registers.
  logic [RegW-1:0] roi_left_q, roi_top_q, roi_right_q, roi_bottom_q;
  logic [RegW-1:0] img_width_q, img_height_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_left_q   <= RegW'(1);
      roi_top_q    <= RegW'(1);
      roi_right_q  <= RegW'(MAX_DIM);
      roi_bottom_q <= RegW'(MAX_DIM);
      img_width_q  <= RegW'(MAX_DIM);
      img_height_q <= RegW'(MAX_DIM);
    end else if (cfg_we) begin
      case (paddr[4:2])
        rcnf_pkg::RegRoiLeft:   roi_left_q   <= pwdata[RegW-1:0];
        rcnf_pkg::RegRoiTop:    roi_top_q    <= pwdata[RegW-1:0];
        rcnf_pkg::RegRoiRight:  roi_right_q  <= pwdata[RegW-1:0];
        rcnf_pkg::RegRoiBottom: roi_bottom_q <= pwdata[RegW-1:0];
        rcnf_pkg::RegImgWidth:  img_width_q  <= pwdata[RegW-1:0];
        rcnf_pkg::RegImgHeight: img_height_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rcnf_pkg::RegRoiLeft:   prdata = 32'(roi_left_q);
      rcnf_pkg::RegRoiTop:    prdata = 32'(roi_top_q);
      rcnf_pkg::RegRoiRight:  prdata = 32'(roi_right_q);
      rcnf_pkg::RegRoiBottom: prdata = 32'(roi_bottom_q);
      rcnf_pkg::RegImgWidth:  prdata = 32'(img_width_q);
      rcnf_pkg::RegImgHeight: prdata = 32'(img_height_q);
      default:                prdata = 32'd0;
    endcase
  end

  // Input fields.
  logic [1:0]  in_req;
  logic [14:0] in_bin;
  logic [2:0]  in_slot;
  logic [15:0] in_weight;
  logic [11:0] in_row, in_col;
  logic [7:0]  in_red, in_green, in_blue;

  assign in_req    = s_axis_tuser_i;
  assign in_bin    = s_axis_tdata_i[14:0];
  assign in_slot   = s_axis_tdata_i[17:15];
  assign in_weight = s_axis_tdata_i[33:18];
  assign in_row    = s_axis_tdata_i[45:34];
  assign in_col    = s_axis_tdata_i[57:46];
  assign in_red    = s_axis_tdata_i[65:58];
  assign in_green  = s_axis_tdata_i[73:66];
  assign in_blue   = s_axis_tdata_i[81:74];

  rcnf_pkg::state_e state_q, state_d;

  logic in_acc, tbl_we, pix_acc, frame_acc, in_roi, region_bad;
  logic [RegW-1:0] row1, col1;
  logic [rcnf_pkg::BinW-1:0] pix_bin;

  assign s_axis_tready_o = (state_q == rcnf_pkg::S_IDLE);
  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign row1      = RegW'(in_row) + RegW'(1);
  assign col1      = RegW'(in_col) + RegW'(1);
  assign in_roi    = (col1 >= roi_left_q) && (col1 <= roi_right_q) &&
                     (row1 >= roi_top_q) && (row1 <= roi_bottom_q);
  assign tbl_we    = in_acc && (in_req == rcnf_pkg::ReqTblWrite) &&
                     (32'(in_slot) < FEATURE_CLASSES);
  assign pix_acc   = in_acc && (in_req == rcnf_pkg::ReqPixel) && in_roi;
  assign frame_acc = in_acc && (in_req == rcnf_pkg::ReqFrameEnd);
  assign pix_bin   = {in_blue[7:3], in_green[7:3], in_red[7:3]};
  assign region_bad = (roi_right_q > img_width_q) || (roi_bottom_q > img_height_q);

  // Weight table: one wide word per bin, one lane per class, lane write enables.
  logic [LaneW-1:0] tbl_mem_q [rcnf_pkg::ColorBins];
  logic [LaneW-1:0] tbl_rd_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FEATURE_CLASSES; k++) begin
      if (tbl_we && (32'(in_slot) == k)) begin
        tbl_mem_q[in_bin][k*WEIGHT_BITS +: WEIGHT_BITS] <= WEIGHT_BITS'(in_weight);
      end
    end
    if (pix_acc) begin
      tbl_rd_q <= tbl_mem_q[pix_bin];
    end
  end

  // Control and datapath registers.
  logic            pix_pend_q;
  logic [AccW-1:0] acc_q [FEATURE_CLASSES];
  logic [AccW-1:0] acc_d [FEATURE_CLASSES];
  logic [AccW-1:0] or_q;
  logic [ClsW-1:0] cls_q;
  logic [1:0]      status_q;
  logic [4:0]      cnt_q;
  logic            out_vld_q, out_last_q;
  logic [2:0]      out_cls_q;
  logic [rcnf_pkg::ValW-1:0] out_val_q;
  logic [1:0]      out_stat_q;

  logic [59:0] prod_q;
  logic [63:0] sum_q, v_q, res_q, bit_q;
  logic [31:0] rem_q;
  logic [rcnf_pkg::QuotSteps-1:0] num_q, quo_q;

  logic shift_en, load_en, cls_last, clr_acc;
  logic [rcnf_pkg::ScaleW-1:0] a_sel;
  logic [AccW-1:0] or_all;
  logic [63:0] trial;
  logic [46:0] num;
  logic [32:0] rem2;
  logic [rcnf_pkg::ValW-1:0] val_sat;
  logic [3:0] cls_wide;

  assign cls_last = (cls_q == ClsW'(FEATURE_CLASSES - 1));
  assign a_sel    = acc_q[cls_q][rcnf_pkg::ScaleW-1:0];
  assign trial    = res_q + bit_q;
  assign num      = 47'({a_sel, 16'h0000}) + 47'(res_q[31:1]);
  assign rem2     = {rem_q, num_q[rcnf_pkg::QuotSteps-1]};
  assign val_sat  = (quo_q > 17'd65536) ? 17'd65536 : quo_q;
  assign cls_wide = 4'(cls_q);

  always_comb begin
    or_all = '0;
    for (int k = 0; k < FEATURE_CLASSES; k++) begin
      or_all = or_all | acc_q[k];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcnf_pkg::S_IDLE:  if (frame_acc) state_d = rcnf_pkg::S_PREP;
      rcnf_pkg::S_PREP:  state_d = (status_q == rcnf_pkg::StatRegion) ?
                                   rcnf_pkg::S_LOAD : rcnf_pkg::S_SHIFT;
      rcnf_pkg::S_SHIFT: begin
        if (or_q == '0) begin
          state_d = rcnf_pkg::S_LOAD;
        end else if (or_q[AccW-1:rcnf_pkg::ScaleW] == '0) begin
          state_d = rcnf_pkg::S_MUL;
        end
      end
      rcnf_pkg::S_MUL:   state_d = rcnf_pkg::S_ADD;
      rcnf_pkg::S_ADD:   state_d = cls_last ? rcnf_pkg::S_SQRT : rcnf_pkg::S_MUL;
      rcnf_pkg::S_SQRT:  if (bit_q[0]) state_d = rcnf_pkg::S_DINIT;
      rcnf_pkg::S_DINIT: state_d = rcnf_pkg::S_DIV;
      rcnf_pkg::S_DIV:   if (cnt_q == 5'd1) state_d = rcnf_pkg::S_LOAD;
      rcnf_pkg::S_LOAD: begin
        if (load_en) begin
          if (cls_last) begin
            state_d = rcnf_pkg::S_IDLE;
          end else if (status_q != rcnf_pkg::StatOk) begin
            state_d = rcnf_pkg::S_LOAD;
          end else begin
            state_d = rcnf_pkg::S_DINIT;
          end
        end
      end
      default:           state_d = rcnf_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    shift_en = 1'b0;
    load_en  = 1'b0;
    case (state_q)
      rcnf_pkg::S_SHIFT: shift_en = (or_q[AccW-1:rcnf_pkg::ScaleW] != '0);
      rcnf_pkg::S_LOAD:  load_en  = !out_vld_q || m_axis_tready_i;
      default: ;
    endcase
  end
  assign clr_acc = load_en && cls_last;

  // Accumulators: saturating add of a bin's weights, scaling shift, clear.
  always_comb begin
    logic [AccW:0] s;
    for (int k = 0; k < FEATURE_CLASSES; k++) begin
      s = (AccW+1)'(acc_q[k]) + (AccW+1)'(tbl_rd_q[k*WEIGHT_BITS +: WEIGHT_BITS]);
      acc_d[k] = acc_q[k];
      if (pix_pend_q) begin
        acc_d[k] = s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
      end else if (shift_en) begin
        acc_d[k] = acc_q[k] >> 1;
      end else if (clr_acc) begin
        acc_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rcnf_pkg::S_IDLE;
      pix_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
      cls_q      <= '0;
      cnt_q      <= '0;
      status_q   <= rcnf_pkg::StatOk;
      for (int k = 0; k < FEATURE_CLASSES; k++) begin
        acc_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      pix_pend_q <= pix_acc;
      for (int k = 0; k < FEATURE_CLASSES; k++) begin
        acc_q[k] <= acc_d[k];
      end
      if (frame_acc) begin
        status_q <= region_bad ? rcnf_pkg::StatRegion : rcnf_pkg::StatOk;
        cls_q    <= '0;
      end
      if ((state_q == rcnf_pkg::S_SHIFT) && (or_q == '0)) begin
        status_q <= rcnf_pkg::StatZero;
      end
      if (state_q == rcnf_pkg::S_ADD) begin
        cls_q <= cls_last ? '0 : cls_q + ClsW'(1);
      end
      if (state_q == rcnf_pkg::S_DINIT) begin
        cnt_q <= 5'(rcnf_pkg::QuotSteps);
      end else if (state_q == rcnf_pkg::S_DIV) begin
        cnt_q <= cnt_q - 5'd1;
      end
      if (load_en) begin
        out_vld_q <= 1'b1;
        cls_q     <= cls_last ? '0 : cls_q + ClsW'(1);
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rcnf_pkg::S_PREP) begin
      or_q <= or_all;
    end else if (shift_en) begin
      or_q <= or_q >> 1;
    end
    if (state_q == rcnf_pkg::S_SHIFT) begin
      sum_q <= '0;
    end
    if (state_q == rcnf_pkg::S_MUL) begin
      prod_q <= a_sel * a_sel;
    end
    if (state_q == rcnf_pkg::S_ADD) begin
      sum_q <= sum_q + 64'(prod_q);
    end
    // Bit-serial integer square root, two radicand bits per step.
    if ((state_q == rcnf_pkg::S_ADD) && cls_last) begin
      v_q   <= sum_q + 64'(prod_q);
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (state_q == rcnf_pkg::S_SQRT) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    // Restoring divider: the quotient fits in 17 bits, so the upper numerator
    // bits start out as the remainder.
    if (state_q == rcnf_pkg::S_DINIT) begin
      rem_q <= 32'(num[46:rcnf_pkg::QuotSteps]);
      num_q <= num[rcnf_pkg::QuotSteps-1:0];
      quo_q <= '0;
    end else if (state_q == rcnf_pkg::S_DIV) begin
      if (rem2 >= {1'b0, res_q[31:0]}) begin
        rem_q <= 32'(rem2 - {1'b0, res_q[31:0]});
        quo_q <= {quo_q[rcnf_pkg::QuotSteps-2:0], 1'b1};
      end else begin
        rem_q <= rem2[31:0];
        quo_q <= {quo_q[rcnf_pkg::QuotSteps-2:0], 1'b0};
      end
      num_q <= {num_q[rcnf_pkg::QuotSteps-2:0], 1'b0};
    end
    if (load_en) begin
      out_cls_q  <= cls_wide[2:0];
      out_val_q  <= (status_q == rcnf_pkg::StatOk) ? val_sat : '0;
      out_stat_q <= status_q;
      out_last_q <= cls_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_stat_q, out_val_q, out_cls_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_pend_q |-> (state_q == rcnf_pkg::S_IDLE || state_q == rcnf_pkg::S_PREP))
    else $error("pixel accumulate pending during frame-end processing");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rcnf_pkg::S_DIV) |-> (rem_q < res_q[31:0]))
    else $error("divider remainder not below the norm");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_acc |=> (or_all == '0))
    else $error("accumulators not cleared after the last result");

  a_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_en && status_q == rcnf_pkg::StatOk) |-> (quo_q <= 17'd65536))
    else $error("normalized value above one");
`endif

endmodule
`default_nettype wire

[tb/rcnf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnf_checker
// Watches the configuration port and both streams of the colour-name feature
// block. It keeps its own weight table, accumulators and region registers,
// predicts the eight feature values of every frame end and compares each
// output transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module rcnf_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [87:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [23:0] m_axis_tdata_i,
  input  wire logic        m_axis_tlast_i,
  output int               fail_count_o,
  output int               pending_o
);

  localparam int unsigned Classes = 8;
  localparam int unsigned AccW = rcnf_pkg::AccW;
  localparam int unsigned RegW = rcnf_pkg::RegW;
  localparam int unsigned ValW = rcnf_pkg::ValW;
  localparam logic [AccW-1:0] AccSat = {AccW{1'b1}};

  typedef struct packed {
    logic [2:0]      cls;
    logic [ValW-1:0] value;
    logic [1:0]      status;
    logic            last;
  } feature_t;

  logic [15:0]     weight_table [int];
  logic [AccW-1:0] class_acc [Classes];
  logic [RegW-1:0] roi_left, roi_top, roi_right, roi_bottom, img_width, img_height;
  feature_t        feature_queue [$];

  assign pending_o = feature_queue.size();

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  task automatic add_pixel(input logic [87:0] d);
    logic [12:0] row1, col1;
    logic [14:0] bin;
    logic [15:0] w;
    logic [AccW:0] total;
    row1 = {1'b0, d[45:34]} + 13'd1;
    col1 = {1'b0, d[57:46]} + 13'd1;
    if (col1 < roi_left || col1 > roi_right || row1 < roi_top || row1 > roi_bottom) return;
    bin = {d[81:77], d[73:69], d[65:61]};
    for (int k = 0; k < Classes; k++) begin
      w = weight_table.exists(int'(bin) * Classes + k) ? weight_table[int'(bin) * Classes + k]
                                                       : 16'd0;
      total = {1'b0, class_acc[k]} + w;
      class_acc[k] = total[AccW] ? AccSat : total[AccW-1:0];
    end
  endtask

  task automatic close_frame();
    logic [AccW-1:0] maxa;
    logic [63:0]     sum, norm, a, q;
    int              shift;
    logic [1:0]      status;
    feature_t        f;
    maxa = 0;
    sum = 0;
    shift = 0;
    norm = 0;
    foreach (class_acc[k]) if (class_acc[k] > maxa) maxa = class_acc[k];
    if (roi_right > img_width || roi_bottom > img_height) status = rcnf_pkg::StatRegion;
    else if (maxa == 0) status = rcnf_pkg::StatZero;
    else status = rcnf_pkg::StatOk;
    if (status == rcnf_pkg::StatOk) begin
      while ((maxa >> shift) >= (40'd1 << rcnf_pkg::ScaleW)) shift++;
      foreach (class_acc[k]) begin
        a = 64'(class_acc[k] >> shift);
        sum += a * a;
      end
      norm = sqrt_floor(sum);
    end
    for (int k = 0; k < Classes; k++) begin
      f.cls = k[2:0];
      f.status = status;
      f.last = (k == Classes - 1);
      f.value = 0;
      if (status == rcnf_pkg::StatOk) begin
        a = 64'(class_acc[k] >> shift);
        q = ((a << 16) + (norm >> 1)) / norm;
        f.value = (q > 64'd65536) ? 17'd65536 : q[ValW-1:0];
      end
      feature_queue.push_back(f);
      class_acc[k] = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    feature_t exp_f, got;
    if (!rst_ni) begin
      foreach (class_acc[k]) class_acc[k] = 0;
      roi_left = 1;
      roi_top = 1;
      roi_right = 4096;
      roi_bottom = 4096;
      img_width = 4096;
      img_height = 4096;
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          rcnf_pkg::RegRoiLeft:   roi_left = pwdata[RegW-1:0];
          rcnf_pkg::RegRoiTop:    roi_top = pwdata[RegW-1:0];
          rcnf_pkg::RegRoiRight:  roi_right = pwdata[RegW-1:0];
          rcnf_pkg::RegRoiBottom: roi_bottom = pwdata[RegW-1:0];
          rcnf_pkg::RegImgWidth:  img_width = pwdata[RegW-1:0];
          rcnf_pkg::RegImgHeight: img_height = pwdata[RegW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (s_axis_tuser_i)
          rcnf_pkg::ReqTblWrite: weight_table[int'(s_axis_tdata_i[14:0]) * Classes
                                   + int'(s_axis_tdata_i[17:15])] = s_axis_tdata_i[33:18];
          rcnf_pkg::ReqPixel:    add_pixel(s_axis_tdata_i);
          rcnf_pkg::ReqFrameEnd: close_frame();
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.cls = m_axis_tdata_i[2:0];
        got.value = m_axis_tdata_i[19:3];
        got.status = m_axis_tdata_i[21:20];
        got.last = m_axis_tlast_i;
        if (feature_queue.size() == 0) begin
          $error("unexpected output transaction: class %0d value %0d", got.cls, got.value);
          fail_count_o++;
        end else begin
          exp_f = feature_queue.pop_front();
          if (got.cls !== exp_f.cls) begin
            $error("feature_class: expected %0d, actual %0d", exp_f.cls, got.cls);
            fail_count_o++;
          end
          if (got.value !== exp_f.value) begin
            $error("feature_value: expected %0d, actual %0d", exp_f.value, got.value);
            fail_count_o++;
          end
          if (got.status !== exp_f.status) begin
            $error("status: expected %0d, actual %0d", exp_f.status, got.status);
            fail_count_o++;
          end
          if (got.last !== exp_f.last) begin
            $error("last: expected %0d, actual %0d", exp_f.last, got.last);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[tb/tb_roi_color_name_feature_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_roi_color_name_feature_top
// Stimulus for the colour-name feature block: loads a set of fully written
// colour bins, then runs frames of pixels, table writes and frame ends under
// six region settings and three idling modes. The checker judges the outputs.
// ----------------------------------------------------------------------------
module tb_roi_color_name_feature_top;

  localparam int NumBins = 6;
  localparam logic [1:0] ReqNone = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [87:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  int          fail_count, pending;
  int          send_idle_pct = 19, recv_stall_pct = 85;

  logic [14:0] ready_bins [NumBins];
  logic [12:0] region_cfg [6][6] = '{
    '{13'd1, 13'd1, 13'd4096, 13'd4096, 13'd4096, 13'd4096},
    '{13'd3, 13'd2, 13'd20, 13'd12, 13'd64, 13'd32},
    '{13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096},
    '{13'd1, 13'd1, 13'd4096, 13'd4096, 13'd100, 13'd4096},
    '{13'd10, 13'd5, 13'd200, 13'd90, 13'd200, 13'd90},
    '{13'd1, 13'd1, 13'd1, 13'd1, 13'd1, 13'd1}};
  logic [2:0] reg_ids [6] = '{rcnf_pkg::RegRoiLeft, rcnf_pkg::RegRoiTop,
                              rcnf_pkg::RegRoiRight, rcnf_pkg::RegRoiBottom,
                              rcnf_pkg::RegImgWidth, rcnf_pkg::RegImgHeight};

  roi_color_name_feature_top dut (.*);

  rcnf_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tlast_i(m_axis_tlast_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [87:0] noise();
    return {24'd0, 32'($urandom), 32'($urandom)} | (88'($urandom_range(255, 0)) << 64);
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [87:0] data, input bit gaps);
    if (gaps && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= data & {6'd0, {82{1'b1}}};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [14:0] bin, input logic [2:0] slot,
                              input logic [15:0] w);
    logic [87:0] d;
    d = noise();
    d[14:0] = bin;
    d[17:15] = slot;
    d[33:18] = w;
    send_req(rcnf_pkg::ReqTblWrite, d, 1'b1);
  endtask

  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col,
                            input logic [14:0] bin, input bit gaps);
    logic [87:0] d;
    d = noise();
    d[45:34] = row;
    d[57:46] = col;
    d[65:58] = {bin[4:0], 3'($urandom)};
    d[73:66] = {bin[9:5], 3'($urandom)};
    d[81:74] = {bin[14:10], 3'($urandom)};
    send_req(rcnf_pkg::ReqPixel, d, gaps);
  endtask

  // Drain all predicted results, then give the block time to finish.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic apply_region(input int p);
    for (int i = 0; i < 6; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_ids[i], 2'b00};
      pwdata <= {19'd0, region_cfg[p][i]};
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [11:0] near_pos(input logic [12:0] lo, input logic [12:0] hi);
    int a, b;
    a = (lo > 3) ? lo - 3 : 0;
    b = (hi > 4095) ? 4095 : hi;
    return 12'($urandom_range(b, a));
  endfunction

  task automatic random_items(input int p, input int count);
    int done, pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        write_weight(ready_bins[$urandom_range(NumBins - 1, 2)], 3'($urandom),
                     16'($urandom));
        done++;
      end else if (pick < 15) begin
        send_req(ReqNone, noise(), 1'b1);
      end else if (pick < 90) begin
        if ($urandom_range(3) != 0)
          send_pixel(near_pos(region_cfg[p][1], region_cfg[p][3]),
                     near_pos(region_cfg[p][0], region_cfg[p][2]),
                     ready_bins[$urandom_range(NumBins - 1)], 1'b1);
        else
          send_pixel(12'($urandom), 12'($urandom), ready_bins[$urandom_range(NumBins - 1)],
                     1'b1);
        done++;
      end else begin
        send_req(rcnf_pkg::ReqFrameEnd, noise(), 1'b1);
        done++;
      end
    end
    send_req(rcnf_pkg::ReqFrameEnd, noise(), 1'b1);
  endtask

  initial begin
    ready_bins = '{15'd0, 15'd32767, 15'h5555, 15'h2AAA, 15'($urandom), 15'($urandom)};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every class of the bins that pixels may address; bin 0 stays all zero
    // and bin 32767 holds the largest weight in every class.
    for (int b = 0; b < NumBins; b++)
      for (int k = 0; k < 8; k++)
        write_weight(ready_bins[b], 3'(k),
                     (b == 0) ? 16'd0 : (b == 1) ? 16'hFFFF : 16'($urandom));

    // Directed frames under the reset region.
    send_pixel(12'd0, 12'd0, 15'd0, 1'b0);
    send_req(rcnf_pkg::ReqFrameEnd, noise(), 1'b0);
    send_pixel(12'd4095, 12'd4095, 15'd32767, 1'b0);
    send_pixel(12'd0, 12'd4095, 15'h5555, 1'b0);
    send_pixel(12'd4095, 12'd0, 15'h2AAA, 1'b0);
    send_req(ReqNone, noise(), 1'b0);
    send_req(rcnf_pkg::ReqFrameEnd, noise(), 1'b0);
    send_req(rcnf_pkg::ReqFrameEnd, noise(), 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 19 : (p < 4) ? 85 : 0;
      recv_stall_pct = (p < 2) ? 85 : (p < 4) ? 19 : 0;
      apply_region(p);
      random_items(p, 47);
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
